@@ rtl/core/ssg_pkg.sv @@
// Shared types and constants for the stepper step generator.
package ssg_pkg;

    localparam int COIL_COUNT = 4;
    localparam int COIL_W     = $clog2(COIL_COUNT);
    localparam int COIL_OUT_W = 4;
    localparam int SPEED_W    = 16;
    localparam int MAXSPD_W   = 15;
    localparam int TRATE_W    = 20;
    localparam int ACC_W      = 21;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [MAXSPD_W-1:0] SPEED_CAP_RST = MAXSPD_W'(1000);
    localparam logic [TRATE_W-1:0]  TICK_RATE_RST = TRATE_W'(10000);

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SPEED  = 2'd1,
        KIND_TARGET = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_VEL  = 2'd1,
        MODE_POS  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_CAP = 1'b0,
        CFG_TICK_RATE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [COIL_OUT_W-1:0] coil_drive;
        logic                  step_pulse;
        logic                  dir_level;
        logic                  enable_level;
        logic [1:0]            mode_now;
        logic [POS_W-1:0]      position_now;
    } t_result;

endpackage

@@ rtl/core/ssg_motion.sv @@
// Motion state, config registers and per-beat state update of the step generator.
module ssg_motion (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_accept,
    input  logic [1:0]                       i_kind,
    input  logic signed [ssg_pkg::SPEED_W-1:0] i_speed_request,
    input  logic signed [ssg_pkg::POS_W-1:0] i_target_position,
    output ssg_pkg::t_result                 o_result
);
    import ssg_pkg::*;

    logic [MAXSPD_W-1:0] r_speed_cap;
    logic [TRATE_W-1:0]  r_tick_rate;

    t_mode               r_mode, n_mode;
    t_dir                r_dir, n_dir;
    logic [MAXSPD_W-1:0] r_rate, n_rate;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [POS_W-1:0]    r_position, n_position;
    logic [POS_W-1:0]    r_target, n_target;
    logic [COIL_W-1:0]   r_coil, n_coil;
    logic                r_energized, n_energized;
    logic                r_dir_pin, n_dir_pin;

    logic [TRATE_W-1:0]  eff_tr;
    logic [SPEED_W-1:0]  mag;
    logic [POS_W-1:0]    diff;
    logic [TRATE_W-1:0]  add_rate;
    logic [ACC_W:0]      sum;
    logic                pulse;
    logic [COIL_OUT_W-1:0] coil_hot;

    assign eff_tr = (r_tick_rate == '0) ? TRATE_W'(1) : r_tick_rate;

    always_comb begin
        n_mode      = r_mode;
        n_dir       = r_dir;
        n_rate      = r_rate;
        n_acc       = r_acc;
        n_position  = r_position;
        n_target    = r_target;
        n_coil      = r_coil;
        n_energized = r_energized;
        n_dir_pin   = r_dir_pin;
        pulse       = 1'b0;
        mag         = '0;
        diff        = '0;
        add_rate    = '0;
        sum         = '0;
        case (i_kind)
            KIND_SPEED: begin
                mag = i_speed_request[SPEED_W-1] ? SPEED_W'(~i_speed_request + 1'b1)
                                                 : SPEED_W'(i_speed_request);
                if (mag > {1'b0, r_speed_cap}) begin
                    mag = {1'b0, r_speed_cap};
                end
                if (TRATE_W'(mag) > eff_tr) begin
                    mag = eff_tr[SPEED_W-1:0];
                end
                if (i_speed_request == '0) begin
                    n_dir  = DIR_NONE;
                    n_mode = MODE_IDLE;
                end else begin
                    n_dir     = i_speed_request[SPEED_W-1] ? DIR_REV : DIR_FWD;
                    n_dir_pin = i_speed_request[SPEED_W-1];
                    n_rate    = mag[MAXSPD_W-1:0];
                    n_acc     = '0;
                    n_mode    = MODE_VEL;
                end
            end
            KIND_TARGET: begin
                n_target = i_target_position;
                diff     = i_target_position - r_position;
                if (diff == '0) begin
                    n_dir  = DIR_NONE;
                    n_mode = MODE_IDLE;
                end else begin
                    n_dir     = diff[POS_W-1] ? DIR_REV : DIR_FWD;
                    n_dir_pin = diff[POS_W-1];
                    n_mode    = MODE_POS;
                end
            end
            KIND_TICK: begin
                if (r_mode != MODE_IDLE) begin
                    if (r_mode == MODE_POS && r_position == r_target) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        add_rate = (TRATE_W'(r_rate) < eff_tr) ? TRATE_W'(r_rate) : eff_tr;
                        sum = {1'b0, r_acc} + (ACC_W+1)'(add_rate);
                        if (sum >= (ACC_W+1)'(eff_tr)) begin
                            sum         = sum - (ACC_W+1)'(eff_tr);
                            n_energized = 1'b1;
                            pulse       = (r_dir != DIR_NONE);
                            if (r_dir == DIR_FWD) begin
                                n_coil     = (r_coil == '0) ? COIL_W'(COIL_COUNT - 1)
                                                            : r_coil - 1'b1;
                                n_position = r_position + 1'b1;
                            end else if (r_dir == DIR_REV) begin
                                n_coil     = (r_coil == COIL_W'(COIL_COUNT - 1)) ? '0
                                                                             : r_coil + 1'b1;
                                n_position = r_position - 1'b1;
                            end
                        end
                        n_acc = sum[ACC_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign coil_hot = COIL_OUT_W'(1) << n_coil;

    always_comb begin
        o_result.coil_drive   = n_energized ? coil_hot : '0;
        o_result.step_pulse   = pulse;
        o_result.dir_level    = n_dir_pin;
        o_result.enable_level = (n_mode != MODE_IDLE);
        o_result.mode_now     = n_mode;
        o_result.position_now = n_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_cap <= SPEED_CAP_RST;
            r_tick_rate <= TICK_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED_CAP: r_speed_cap <= i_cfg_data[MAXSPD_W-1:0];
                CFG_TICK_RATE: r_tick_rate <= i_cfg_data[TRATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_dir       <= DIR_NONE;
            r_rate      <= '0;
            r_acc       <= '0;
            r_position  <= '0;
            r_target    <= '0;
            r_coil      <= '0;
            r_energized <= 1'b0;
            r_dir_pin   <= 1'b1;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_dir       <= n_dir;
            r_rate      <= n_rate;
            r_acc       <= n_acc;
            r_position  <= n_position;
            r_target    <= n_target;
            r_coil      <= n_coil;
            r_energized <= n_energized;
            r_dir_pin   <= n_dir_pin;
        end
    end

    a_coil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coil <= COIL_W'(COIL_COUNT - 1))
        else $error("coil index out of range");

    a_moving_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_IDLE) |-> (r_dir != DIR_NONE))
        else $error("active mode without direction");

    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.step_pulse) |=> (r_position != $past(r_position)))
        else $error("step beat did not move position");

    a_rate_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_kind == KIND_SPEED && i_speed_request != '0)
        |=> (TRATE_W'(r_rate) <= $past(eff_tr)))
        else $error("rate exceeds tick rate");

endmodule

@@ rtl/core/stepper_step_generator.sv @@
// Top level of the stepper step generator: ports, result register and skid stage.
//
// Input channel: i_in_valid / o_in_stall carry one beat of kind, speed request
// and target position; a beat is taken on an edge with valid high and stall low.
// Kind 0 is a timer tick, 1 sets a signed speed, 2 sets an absolute target.
// Output channel: o_out_valid / i_out_stall carry one result beat per input
// beat, in order: coil pattern, step pulse, direction, enable, mode, position.
// Config channel: i_cfg_valid / o_cfg_ready writes max speed (index 0) or the
// tick rate (index 1); ready is always high. Write only while no beat is in
// flight.
// Each result is registered before it reaches the output. Throughput: one
// beat per cycle while o_in_stall is low, set by the combinational state
// update (accumulate, compare, position increment) feeding the state registers.
// A two-entry output buffer (result register plus skid register) lets input
// continue while a result waits; o_in_stall rises only when both are full.
// Reset (synchronous, active low) clears the motion state to idle at position
// zero, loads max speed 1000 and tick rate 10000, and empties the buffer.
module stepper_step_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic signed [ssg_pkg::SPEED_W-1:0] i_speed_request,
    input  logic signed [ssg_pkg::POS_W-1:0]   i_target_position,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ssg_pkg::COIL_OUT_W-1:0]     o_coil_drive,
    output logic                               o_step_pulse,
    output logic                               o_dir_level,
    output logic                               o_enable_level,
    output logic [1:0]                         o_mode_now,
    output logic signed [ssg_pkg::POS_W-1:0]   o_position_now,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ssg_pkg::*;

    t_result new_res;
    t_result r_out, r_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    logic    in_acc, take_out, load_out_new, load_out_skid, load_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign take_out    = r_out_valid && !i_out_stall;

    assign load_out_skid = take_out && r_skid_valid;
    assign load_out_new  = in_acc && (!r_out_valid || take_out);
    assign load_skid     = in_acc && r_out_valid && !take_out;

    assign n_out_valid  = (r_out_valid && !take_out) || load_out_new || load_out_skid;
    assign n_skid_valid = r_skid_valid ? !take_out : load_skid;

    ssg_motion u_motion (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_accept          (in_acc),
        .i_kind            (i_kind),
        .i_speed_request   (i_speed_request),
        .i_target_position (i_target_position),
        .o_result          (new_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skid) begin
            r_out <= r_skid;
        end else if (load_out_new) begin
            r_out <= new_res;
        end
        if (load_skid) begin
            r_skid <= new_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_drive   = r_out.coil_drive;
    assign o_step_pulse   = r_out.step_pulse;
    assign o_dir_level    = r_out.dir_level;
    assign o_enable_level = r_out.enable_level;
    assign o_mode_now     = r_out.mode_now;
    assign o_position_now = r_out.position_now;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_coil_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_coil_drive))
        else $error("coil drive not one-hot");

    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_enable_level == (o_mode_now != MODE_IDLE)))
        else $error("enable disagrees with mode");

endmodule

@@ bench/stepper_step_generator_chk.sv @@
// Checker for the stepper step generator: motion prediction and result comparison.
module stepper_step_generator_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic signed [ssg_pkg::SPEED_W-1:0] i_speed_request,
    input  logic signed [ssg_pkg::POS_W-1:0]   i_target_position,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [ssg_pkg::COIL_OUT_W-1:0]     i_coil_drive,
    input  logic                               i_step_pulse,
    input  logic                               i_dir_level,
    input  logic                               i_enable_level,
    input  logic [1:0]                         i_mode_now,
    input  logic signed [ssg_pkg::POS_W-1:0]   i_position_now,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_result_count,
    output int                                 o_step_count,
    output logic signed [ssg_pkg::POS_W-1:0]   o_position
);
    import ssg_pkg::*;

    localparam int MAX_REPORTS = 20;

    logic [MAXSPD_W-1:0] speed_cap;
    logic [TRATE_W-1:0]  tick_rate;
    t_mode               mode;
    t_dir                heading;
    logic [TRATE_W-1:0]  rate;
    logic [ACC_W-1:0]    accum;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    target;
    logic [COIL_W-1:0]   coil;
    logic                energized;
    logic                dir_pin;
    t_result             due_results[$];

    task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("MISMATCH at result %0d: %s expected %0h got %0h",
                     o_result_count, what, want, got);
        end
    endtask

    task take_heading(input t_dir d);
        heading = d;
        if (d == DIR_FWD) begin
            dir_pin = 1'b0;
        end else if (d == DIR_REV) begin
            dir_pin = 1'b1;
        end
    endtask

    task advance_motion(input logic [1:0] kind, input logic signed [SPEED_W-1:0] spd,
                        input logic [POS_W-1:0] tgt);
        int          eff;
        int          mag;
        int          add;
        int          sum;
        int          ci;
        logic [31:0] diff;
        logic        pulse;
        t_result     res;
        eff   = (tick_rate == 0) ? 1 : int'(tick_rate);
        pulse = 1'b0;
        case (kind)
            KIND_SPEED: begin
                take_heading(spd > 0 ? DIR_FWD : (spd < 0 ? DIR_REV : DIR_NONE));
                if (spd != 0) begin
                    mag = int'(spd);
                    if (mag < 0) mag = -mag;
                    if (mag > int'(speed_cap)) mag = int'(speed_cap);
                    if (mag > eff) mag = eff;
                    rate  = TRATE_W'(mag);
                    accum = '0;
                    mode  = MODE_VEL;
                end else begin
                    mode = MODE_IDLE;
                end
            end
            KIND_TARGET: begin
                target = tgt;
                diff   = target - position;
                take_heading(diff == 0 ? DIR_NONE : (diff[31] ? DIR_REV : DIR_FWD));
                mode = (heading != DIR_NONE) ? MODE_POS : MODE_IDLE;
            end
            KIND_TICK: begin
                if (mode != MODE_IDLE) begin
                    if (mode == MODE_POS && position == target) begin
                        mode = MODE_IDLE;
                    end else begin
                        add = (int'(rate) < eff) ? int'(rate) : eff;
                        sum = int'(accum) + add;
                        if (sum >= eff) begin
                            sum = sum - eff;
                            ci  = int'(coil) % COIL_COUNT;
                            if (heading == DIR_FWD) begin
                                ci = (ci + COIL_COUNT - 1) % COIL_COUNT;
                                position = position + 1;
                            end else if (heading == DIR_REV) begin
                                ci = (ci + 1) % COIL_COUNT;
                                position = position - 1;
                            end
                            coil      = COIL_W'(ci);
                            energized = 1'b1;
                            pulse     = (heading != DIR_NONE);
                        end
                        accum = ACC_W'(sum);
                    end
                end
            end
            default: begin
            end
        endcase
        res.coil_drive   = energized ? COIL_OUT_W'(1 << coil) : '0;
        res.step_pulse   = pulse;
        res.dir_level    = dir_pin;
        res.enable_level = (mode != MODE_IDLE);
        res.mode_now     = mode;
        res.position_now = position;
        due_results.push_back(res);
    endtask

    task check_result();
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with none expected, position", 32'd0,
                            32'(i_position_now));
        end else begin
            want = due_results.pop_front();
            if (i_coil_drive !== want.coil_drive)
                report_mismatch("coil_drive", 32'(want.coil_drive), 32'(i_coil_drive));
            if (i_step_pulse !== want.step_pulse)
                report_mismatch("step_pulse", 32'(want.step_pulse), 32'(i_step_pulse));
            if (i_dir_level !== want.dir_level)
                report_mismatch("dir_level", 32'(want.dir_level), 32'(i_dir_level));
            if (i_enable_level !== want.enable_level)
                report_mismatch("enable_level", 32'(want.enable_level),
                                32'(i_enable_level));
            if (i_mode_now !== want.mode_now)
                report_mismatch("mode_now", 32'(want.mode_now), 32'(i_mode_now));
            if (i_position_now !== want.position_now)
                report_mismatch("position_now", want.position_now, 32'(i_position_now));
            if (want.step_pulse) o_step_count++;
        end
        o_result_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_cap      = SPEED_CAP_RST;
            tick_rate      = TICK_RATE_RST;
            mode           = MODE_IDLE;
            heading        = DIR_NONE;
            rate           = '0;
            accum          = '0;
            position       = '0;
            target         = '0;
            coil           = '0;
            energized      = 1'b0;
            dir_pin        = 1'b1;
            o_fail_count   = 0;
            o_result_count = 0;
            o_step_count   = 0;
            due_results.delete();
        end else begin
            // older results leave before this edge's beat is predicted
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEED_CAP: speed_cap = i_cfg_data[MAXSPD_W-1:0];
                    CFG_TICK_RATE: tick_rate = i_cfg_data[TRATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_motion(i_kind, i_speed_request, i_target_position);
            end
        end
        o_pending  = due_results.size();
        o_position = position;
    end

endmodule

@@ bench/stepper_step_generator_tb.sv @@
// Testbench top for the stepper step generator: clock, reset, stimulus and verdict.
module stepper_step_generator_tb;
    import ssg_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_in_valid        = 1'b0;
    logic [1:0]               i_kind            = KIND_TICK;
    logic signed [SPEED_W-1:0] i_speed_request  = '0;
    logic signed [POS_W-1:0]  i_target_position = '0;
    logic                     i_out_stall       = 1'b0;
    logic                     i_cfg_valid       = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index       = CFG_SPEED_CAP;
    logic [CFG_DATA_W-1:0]    i_cfg_data        = '0;

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [COIL_OUT_W-1:0]    o_coil_drive;
    logic                     o_step_pulse;
    logic                     o_dir_level;
    logic                     o_enable_level;
    logic [1:0]               o_mode_now;
    logic signed [POS_W-1:0]  o_position_now;
    logic                     o_cfg_ready;

    int                       chk_fails;
    int                       chk_pending;
    int                       chk_results;
    int                       chk_steps;
    logic signed [POS_W-1:0]  chk_position;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_request    = 1'b0;
    int beats_sent      = 0;
    int settings_used   = 0;

    always #1 i_clk = ~i_clk;

    stepper_step_generator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_speed_request   (i_speed_request),
        .i_target_position (i_target_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_coil_drive      (o_coil_drive),
        .o_step_pulse      (o_step_pulse),
        .o_dir_level       (o_dir_level),
        .o_enable_level    (o_enable_level),
        .o_mode_now        (o_mode_now),
        .o_position_now    (o_position_now),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    stepper_step_generator_chk chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_speed_request   (i_speed_request),
        .i_target_position (i_target_position),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_coil_drive      (o_coil_drive),
        .i_step_pulse      (o_step_pulse),
        .i_dir_level       (o_dir_level),
        .i_enable_level    (o_enable_level),
        .i_mode_now        (o_mode_now),
        .i_position_now    (o_position_now),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (chk_fails),
        .o_pending         (chk_pending),
        .o_result_count    (chk_results),
        .o_step_count      (chk_steps),
        .o_position        (chk_position)
    );

    // result side: random stall, or a long hold-off on request
    initial begin : result_side
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input logic [1:0] kind, input logic [SPEED_W-1:0] spd,
                             input logic [POS_W-1:0] tgt);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_speed_request   <= spd;
        i_target_position <= tgt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] cap_data,
                                input logic [CFG_DATA_W-1:0] rate_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SPEED_CAP;
        i_cfg_data  <= cap_data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_TICK_RATE;
        i_cfg_data  <= rate_data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_beat();
        int                 pick;
        int                 offset;
        logic [SPEED_W-1:0] spd;
        logic [POS_W-1:0]   tgt;
        pick = $urandom_range(0, 99);
        spd  = SPEED_W'($urandom);
        tgt  = $urandom;
        if (pick < 58) begin
            send_beat(KIND_TICK, spd, tgt);
        end else if (pick < 72) begin
            if (pick < 64) begin
                spd = SPEED_W'($urandom_range(1, 300));
            end else if (pick < 68) begin
                spd = SPEED_W'(0 - $urandom_range(1, 300));
            end else if (pick < 70) begin
                spd = '0;
            end
            send_beat(KIND_SPEED, spd, tgt);
        end else if (pick < 88) begin
            // near the current position so position mode runs to its end
            offset = $urandom_range(0, 60);
            tgt    = chk_position + offset - 30;
            send_beat(KIND_TARGET, spd, tgt);
        end else if (pick < 93) begin
            send_beat(KIND_TARGET, spd, tgt);
        end else begin
            send_beat(KIND_UNUSED, spd, tgt);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cap_data,
                             input logic [CFG_DATA_W-1:0] rate_data,
                             input t_pace pace, input int count);
        int n;
        wait_drained();
        program_regs(cap_data, rate_data);
        sender_idle_pct = (pace == PACE_SENDER) ? 61 : ((pace == PACE_BOTH) ? 16 : 0);
        recv_stall_pct  = (pace == PACE_RECEIVER) ? 61 : ((pace == PACE_BOTH) ? 16 : 0);
        for (n = 0; n < count; n++) begin
            if (n == count / 3) hold_request = 1'b1;
            if (n == (2 * count) / 3) wait_drained();
            send_random_beat();
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle tick, unused kind, targets, speed extremes
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_UNUSED, SPEED_W'($urandom), $urandom);
        send_beat(KIND_TARGET, SPEED_W'($urandom), 32'd0);
        send_beat(KIND_TARGET, SPEED_W'($urandom), 32'd3);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_SPEED, 16'h0000, $urandom);
        send_beat(KIND_SPEED, 16'h7FFF, $urandom);
        send_beat(KIND_SPEED, 16'h8000, $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);

        // tick rate zero acts as one; wrapped target distances
        wait_drained();
        program_regs(20'd32767, 20'd0);
        send_beat(KIND_SPEED, 16'd5, $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_TARGET, SPEED_W'($urandom), 32'h7FFF_FFFF);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_TARGET, SPEED_W'($urandom), 32'h8000_0000);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        wait_drained();
        send_beat(KIND_TARGET, SPEED_W'($urandom), chk_position + 2);
        repeat (3) send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);

        // speed cap zero: velocity mode that never steps
        wait_drained();
        program_regs(20'd0, 20'hFFFFF);
        send_beat(KIND_SPEED, 16'd100, $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);

        // large accumulator, then the tick rate lowered under it
        wait_drained();
        program_regs(20'd32767, 20'd1000000);
        send_beat(KIND_SPEED, 16'd30000, $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);
        wait_drained();
        program_regs(20'd32767, 20'd7);
        send_beat(KIND_TICK, SPEED_W'($urandom), $urandom);

        run_phase(20'd32767, 20'd1, PACE_FULL, 90);
        run_phase(20'd1000, 20'd10000, PACE_SENDER, 90);
        run_phase(20'd7, 20'd20, PACE_RECEIVER, 90);
        run_phase(20'd32767, 20'd0, PACE_BOTH, 90);
        run_phase(20'd1, 20'hFFFFF, PACE_FULL, 40);
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 200)), PACE_SENDER, 90);
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 64)), PACE_RECEIVER, 90);
        run_phase(20'd0, 20'd5, PACE_BOTH, 40);
        run_phase(CFG_DATA_W'($urandom_range(50, 400)), CFG_DATA_W'($urandom_range(100, 2000)),
                  PACE_FULL, 90);

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d beats under %0d register settings; %0d results compared, %0d steps.",
                 beats_sent, settings_used, chk_results, chk_steps);
        $display("Mixes of idle and stall, a long result hold-off and drained pauses included.");
        if (chk_pending != 0) begin
            $display("%0d expected results never arrived", chk_pending);
        end
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
